/* rtl/cteb_pkg.sv */
// Shared types and constants for the cone-tool engrave buffer.
// Used by cteb_arith, cteb_store and cone_tool_engrave_buffer_core; no dependencies.
package cteb_pkg;

    // Request kinds carried in tuser.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_CUT   = 2'd1;
    localparam logic [1:0] REQ_NORM  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Operations of the shared arithmetic unit.
    localparam logic ARITH_SQRT = 1'b0;
    localparam logic ARITH_DIV  = 1'b1;

    // Field widths and defaults.
    localparam int CENTER_W        = 18;
    localparam int VAL_W           = 16;
    localparam int SIDE_CFG_W      = 9;
    localparam int MUL_W           = 17;
    localparam int ARITH_N_W       = 64;
    localparam int ARITH_R_W       = 32;
    localparam int DEF_IMAGE_SIDE  = 256;
    localparam int DEF_FRAC_BITS   = 8;
    localparam logic [VAL_W-1:0] PIX_FULL = 16'hFFFF;

    // Control from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic start;
        logic mode;
    } arith_ctrl_t;

endpackage

/* rtl/cone_tool_engrave_buffer_core.sv */
// Cone-tool engrave buffer: a square depth image of 16-bit pixels with clear, cut,
// normalize and read requests, one result transaction per request. The block takes one
// request at a time. Clear writes the whole image, one pixel write a cycle. Normalize
// scans for the minimum and maximum, then rescales each pixel with a divide on the
// shared bit-serial unit, or writes zero to each pixel when the image is flat. Cut
// visits each pixel of the clipped tool window and, for each pixel inside the radius,
// runs the 32-step square root and 32-step divide of that unit.
// Depends on cteb_pkg, cteb_arith and cteb_store.
module cone_tool_engrave_buffer_core #(
    parameter int IMAGE_SIDE = cteb_pkg::DEF_IMAGE_SIDE,
    parameter int FRAC_BITS  = cteb_pkg::DEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: active_side.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cteb_pkg::SIDE_CFG_W-1:0] cfg_data,
    // Requests. tuser: req_type[1:0].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [1:0]                      s_tuser,
    // tdata: center_x[17:0], center_y[35:18], tool_radius[51:36], tool_depth[67:52],
    // pixel_x[83:68], pixel_y[99:84], zero fill [103:100].
    input  logic [103:0]                    s_tdata,
    // Results. tuser: req_echo[1:0].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [1:0]                      m_tuser,
    // tdata: pixel_value[15:0], range_min[31:16], range_max[47:32].
    output logic [47:0]                     m_tdata
);
    import cteb_pkg::*;

    localparam int COORD_W    = $clog2(IMAGE_SIDE);
    localparam int SIDE_W     = $clog2(IMAGE_SIDE + 1);
    localparam int ADDR_W     = $clog2(IMAGE_SIDE * IMAGE_SIDE);
    localparam int CNT_W      = $clog2(IMAGE_SIDE * IMAGE_SIDE + 1);
    localparam int MIN_RADIUS = ((1 << FRAC_BITS) + 9) / 10;
    localparam int WW         = 20;
    localparam int DXW        = ((COORD_W + FRAC_BITS > CENTER_W) ?
                                 (COORD_W + FRAC_BITS) : CENTER_W) + 2;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CNT      = 5'd1;
    localparam logic [4:0] S_CLR      = 5'd2;
    localparam logic [4:0] S_CUT_WIN  = 5'd3;
    localparam logic [4:0] S_CUT_R2   = 5'd4;
    localparam logic [4:0] S_CUT_ADR  = 5'd5;
    localparam logic [4:0] S_CUT_RD   = 5'd6;
    localparam logic [4:0] S_CUT_SQY  = 5'd7;
    localparam logic [4:0] S_CUT_CMP  = 5'd8;
    localparam logic [4:0] S_CUT_N2   = 5'd9;
    localparam logic [4:0] S_CUT_SGO  = 5'd10;
    localparam logic [4:0] S_CUT_SQRT = 5'd11;
    localparam logic [4:0] S_CUT_DGO  = 5'd12;
    localparam logic [4:0] S_CUT_DIV  = 5'd13;
    localparam logic [4:0] S_NRM_SCAN = 5'd14;
    localparam logic [4:0] S_NRM_RA   = 5'd15;
    localparam logic [4:0] S_NRM_RW   = 5'd16;
    localparam logic [4:0] S_NRM_GO   = 5'd17;
    localparam logic [4:0] S_NRM_DIV  = 5'd18;
    localparam logic [4:0] S_RD_ADR   = 5'd19;
    localparam logic [4:0] S_RD_ISS   = 5'd20;
    localparam logic [4:0] S_RD_CAP   = 5'd21;
    localparam logic [4:0] S_OUT      = 5'd22;

    // Truncate a Q value toward zero to whole pixels.
    function automatic logic signed [WW-1:0] trunc_q(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] neg;
        neg = -v;
        return (v < 0) ? -(neg >>> FRAC_BITS) : (v >>> FRAC_BITS);
    endfunction

    // Control and payload registers.
    logic [4:0]                 state_reg, state_next;
    logic [SIDE_CFG_W-1:0]      side_cfg_reg, side_cfg_next;
    logic [1:0]                 req_reg, req_next;
    logic signed [CENTER_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [VAL_W-1:0]           rad_reg, rad_next, base_reg, base_next;
    logic [VAL_W-1:0]           px_reg, px_next, py_reg, py_next;
    logic [CNT_W-1:0]           count_reg, count_next, cnt_reg, cnt_next;
    logic                       vld_reg, vld_next;
    logic [COORD_W-1:0]         x_reg, x_next, y_reg, y_next;
    logic [COORD_W-1:0]         x0_reg, x0_next, x1_reg, x1_next, y1_reg, y1_next;
    logic [31:0]                r2_reg, r2_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [MUL_W-1:0]           adx_reg, adx_next, ady_reg, ady_next;
    logic [34:0]                dd_reg, dd_next;
    logic [VAL_W-1:0]           old_reg, old_next;
    logic [ARITH_N_W-1:0]       wk_reg, wk_next;
    logic [VAL_W-1:0]           den_reg, den_next;
    logic [VAL_W-1:0]           lo_reg, lo_next, hi_reg, hi_next;
    logic [VAL_W-1:0]           pix_out_reg, pix_out_next;

    // Datapath signals.
    logic [SIDE_W-1:0]          side_eff;
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [2*MUL_W-1:0]         mul_p;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
    logic [VAL_W-1:0]           mem_wdata, mem_q;
    arith_ctrl_t                arith_ctrl;
    logic                       arith_done;
    logic [ARITH_R_W-1:0]       arith_res;

    logic [VAL_W-1:0]           r_eff;
    logic signed [WW-1:0]       side_m1, cxw, cyw, rw;
    logic signed [WW-1:0]       xlo_t, xhi_t, ylo_t, yhi_t;
    logic signed [DXW-1:0]      dx, dy, adx_w, ady_w;
    logic [VAL_W-1:0]           diff_p;
    logic [31:0]                nrm_num;
    logic [17:0]                cut_val;

    // Effective side from the configuration register.
    always_comb begin
        if (side_cfg_reg == '0) begin
            side_eff = SIDE_W'(1);
        end else if (32'(side_cfg_reg) > IMAGE_SIDE) begin
            side_eff = SIDE_W'(IMAGE_SIDE);
        end else begin
            side_eff = SIDE_W'(side_cfg_reg);
        end
    end

    // Shared multiplier with operands chosen by the sequencer.
    always_comb begin
        case (state_reg)
            S_CNT:     begin mul_a = MUL_W'(side_eff); mul_b = MUL_W'(side_eff); end
            S_CUT_R2:  begin mul_a = MUL_W'(rad_reg);  mul_b = MUL_W'(rad_reg);  end
            S_CUT_ADR: begin mul_a = MUL_W'(y_reg);    mul_b = MUL_W'(side_eff); end
            S_CUT_RD:  begin mul_a = adx_reg;          mul_b = adx_reg;          end
            S_CUT_SQY: begin mul_a = ady_reg;          mul_b = ady_reg;          end
            S_RD_ADR:  begin mul_a = MUL_W'(py_reg);   mul_b = MUL_W'(side_eff); end
            default:   begin mul_a = '0;               mul_b = '0;               end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Tool window and distance terms.
    always_comb begin
        r_eff   = (32'(s_tdata[51:36]) < MIN_RADIUS) ? VAL_W'(MIN_RADIUS) : s_tdata[51:36];
        side_m1 = WW'(side_eff) - WW'(1);
        cxw     = WW'(cx_reg);
        cyw     = WW'(cy_reg);
        rw      = WW'({1'b0, rad_reg});
        xlo_t   = trunc_q(cxw - rw);
        xhi_t   = trunc_q(cxw + rw);
        ylo_t   = trunc_q(cyw - rw);
        yhi_t   = trunc_q(cyw + rw);
        dx      = $signed({{(DXW-COORD_W-FRAC_BITS){1'b0}}, x_reg, {FRAC_BITS{1'b0}}})
                  - DXW'(cx_reg);
        dy      = $signed({{(DXW-COORD_W-FRAC_BITS){1'b0}}, y_reg, {FRAC_BITS{1'b0}}})
                  - DXW'(cy_reg);
        adx_w   = dx[DXW-1] ? -dx : dx;
        ady_w   = dy[DXW-1] ? -dy : dy;
        diff_p  = mem_q - lo_reg;
        nrm_num = {diff_p, 16'd0} - 32'(diff_p);
        cut_val = {1'b0, arith_res[16:0]} + 18'(base_reg);
    end

    // Request sequencer.
    always_comb begin
        state_next   = state_reg;
        side_cfg_next = side_cfg_reg;
        req_next     = req_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        rad_next     = rad_reg;
        base_next    = base_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        vld_next     = 1'b0;
        x_next       = x_reg;
        y_next       = y_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        r2_next      = r2_reg;
        addr_next    = addr_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        dd_next      = dd_reg;
        old_next     = old_reg;
        wk_next      = wk_reg;
        den_next     = den_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pix_out_next = pix_out_reg;
        mem_we       = 1'b0;
        mem_waddr    = cnt_reg[ADDR_W-1:0];
        mem_wdata    = PIX_FULL;
        mem_raddr    = addr_reg;
        arith_ctrl   = '{start: 1'b0, mode: ARITH_SQRT};

        if (cfg_valid) begin
            side_cfg_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next     = s_tuser;
                    cx_next      = s_tdata[17:0];
                    cy_next      = s_tdata[35:18];
                    rad_next     = r_eff;
                    base_next    = PIX_FULL - s_tdata[67:52];
                    px_next      = s_tdata[83:68];
                    py_next      = s_tdata[99:84];
                    pix_out_next = '0;
                    state_next   = S_CNT;
                end
            end
            S_CNT: begin
                count_next = mul_p[CNT_W-1:0];
                cnt_next   = '0;
                lo_next    = PIX_FULL;
                hi_next    = '0;
                case (req_reg)
                    REQ_CLEAR: state_next = S_CLR;
                    REQ_CUT:   state_next = S_CUT_WIN;
                    REQ_NORM:  state_next = S_NRM_SCAN;
                    default:   state_next = S_RD_ADR;
                endcase
            end
            // Clear sweep, one pixel a cycle.
            S_CLR: begin
                if (cnt_reg == count_reg) begin
                    state_next = S_OUT;
                end else begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            // Cut: window clipping.
            S_CUT_WIN: begin
                x0_next = (xlo_t < 0) ? '0 : xlo_t[COORD_W-1:0];
                x1_next = (xhi_t > side_m1) ? side_m1[COORD_W-1:0] : xhi_t[COORD_W-1:0];
                y1_next = (yhi_t > side_m1) ? side_m1[COORD_W-1:0] : yhi_t[COORD_W-1:0];
                x_next  = (xlo_t < 0) ? '0 : xlo_t[COORD_W-1:0];
                y_next  = (ylo_t < 0) ? '0 : ylo_t[COORD_W-1:0];
                if (xhi_t < 0 || yhi_t < 0 || xlo_t > side_m1 || ylo_t > side_m1) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_CUT_R2;
                end
            end
            S_CUT_R2: begin
                r2_next    = mul_p[31:0];
                state_next = S_CUT_ADR;
            end
            S_CUT_ADR: begin
                addr_next  = mul_p[ADDR_W-1:0] + ADDR_W'(x_reg);
                adx_next   = adx_w[MUL_W-1:0];
                ady_next   = ady_w[MUL_W-1:0];
                state_next = S_CUT_RD;
            end
            S_CUT_RD: begin
                dd_next    = 35'(mul_p);
                state_next = S_CUT_SQY;
            end
            S_CUT_SQY: begin
                dd_next    = dd_reg + 35'(mul_p);
                old_next   = mem_q;
                state_next = S_CUT_CMP;
            end
            S_CUT_CMP: begin
                wk_next    = 64'({dd_reg[31:0], 16'd0}) - 64'(dd_reg[31:0]);
                state_next = S_CUT_N2;
            end
            S_CUT_N2: begin
                wk_next    = {wk_reg[47:0], 16'd0} - wk_reg;
                state_next = S_CUT_SGO;
            end
            S_CUT_SGO: begin
                arith_ctrl = '{start: 1'b1, mode: ARITH_SQRT};
                state_next = S_CUT_SQRT;
            end
            S_CUT_SQRT: begin
                if (arith_done) begin
                    wk_next    = {arith_res, 32'd0};
                    den_next   = rad_reg;
                    state_next = S_CUT_DGO;
                end
            end
            S_CUT_DGO: begin
                arith_ctrl = '{start: 1'b1, mode: ARITH_DIV};
                state_next = S_CUT_DIV;
            end
            S_CUT_DIV: begin
                if (arith_done) begin
                    mem_waddr = addr_reg;
                    mem_wdata = cut_val[VAL_W-1:0];
                    mem_we    = (cut_val < 18'(old_reg));
                end
            end
            // Normalize, first pass: min and max with one read in flight.
            S_NRM_SCAN: begin
                mem_raddr = cnt_reg[ADDR_W-1:0];
                if (cnt_reg != count_reg) begin
                    vld_next = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (vld_reg) begin
                    if (mem_q < lo_reg) lo_next = mem_q;
                    if (mem_q > hi_reg) hi_next = mem_q;
                end else if (cnt_reg == count_reg) begin
                    cnt_next   = '0;
                    state_next = S_NRM_RA;
                end
            end
            // Normalize, second pass: rescale each pixel.
            S_NRM_RA: begin
                mem_raddr = cnt_reg[ADDR_W-1:0];
                state_next = (cnt_reg == count_reg) ? S_OUT : S_NRM_RW;
            end
            S_NRM_RW: begin
                if (hi_reg <= lo_reg) begin
                    mem_we     = 1'b1;
                    mem_wdata  = '0;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_NRM_RA;
                end else begin
                    wk_next    = {nrm_num, 32'd0};
                    den_next   = hi_reg - lo_reg;
                    state_next = S_NRM_GO;
                end
            end
            S_NRM_GO: begin
                arith_ctrl = '{start: 1'b1, mode: ARITH_DIV};
                state_next = S_NRM_DIV;
            end
            S_NRM_DIV: begin
                if (arith_done) begin
                    mem_we     = 1'b1;
                    mem_wdata  = arith_res[VAL_W-1:0];
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_NRM_RA;
                end
            end
            // Read one pixel.
            S_RD_ADR: begin
                addr_next = mul_p[ADDR_W-1:0] + ADDR_W'(px_reg);
                if (32'(px_reg) >= 32'(side_eff) || 32'(py_reg) >= 32'(side_eff)) begin
                    pix_out_next = PIX_FULL;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_RD_ISS;
                end
            end
            S_RD_ISS: begin
                state_next = S_RD_CAP;
            end
            S_RD_CAP: begin
                pix_out_next = mem_q;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Cut: step to the next pixel of the window after a skip or a finished divide and its write.
        if ((state_reg == S_CUT_CMP && dd_reg >= 35'(r2_reg)) ||
            (state_reg == S_CUT_DIV && arith_done)) begin
            if (x_reg == x1_reg) begin
                if (y_reg == y1_reg) begin
                    state_next = S_OUT;
                end else begin
                    x_next     = x0_reg;
                    y_next     = y_reg + COORD_W'(1);
                    state_next = S_CUT_ADR;
                end
            end else begin
                x_next     = x_reg + COORD_W'(1);
                state_next = S_CUT_ADR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            side_cfg_reg <= SIDE_CFG_W'(256);
            vld_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            side_cfg_reg <= side_cfg_next;
            vld_reg      <= vld_next;
        end
        req_reg     <= req_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        rad_reg     <= rad_next;
        base_reg    <= base_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        count_reg   <= count_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        r2_reg      <= r2_next;
        addr_reg    <= addr_next;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        dd_reg      <= dd_next;
        old_reg     <= old_next;
        wk_reg      <= wk_next;
        den_reg     <= den_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pix_out_reg <= pix_out_next;
    end

    cteb_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (arith_ctrl),
        .op_n    (wk_reg),
        .op_d    (den_reg),
        .done    (arith_done),
        .result  (arith_res)
    );

    cteb_store #(
        .DEPTH  (IMAGE_SIDE * IMAGE_SIDE),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    // Handshakes and result transaction.
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tuser   = req_reg;
    assign m_tdata   = (req_reg == REQ_NORM) ? {hi_reg, lo_reg, pix_out_reg}
                                             : {32'd0, pix_out_reg};
endmodule

/* rtl/cteb_arith.sv */
// Shared iterative unit: 64-bit integer square root or 32/16 division,
// one bit per cycle through a single compare-subtract. Depends on cteb_pkg.
module cteb_arith (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cteb_pkg::arith_ctrl_t          ctrl,
    input  logic [cteb_pkg::ARITH_N_W-1:0] op_n,
    input  logic [cteb_pkg::VAL_W-1:0]     op_d,
    output logic                           done,
    output logic [cteb_pkg::ARITH_R_W-1:0] result
);
    import cteb_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 mode_reg, mode_next;
    logic [4:0]           step_reg, step_next;
    logic [ARITH_N_W-1:0] n_reg, n_next;
    logic [VAL_W-1:0]     d_reg, d_next;
    logic [32:0]          rem_reg, rem_next;
    logic [ARITH_R_W-1:0] root_reg, root_next;
    logic [34:0]          a_op, b_op, diff;
    logic                 ge;

    // One shared subtractor; the operands depend on the operation.
    // The square-root remainder reaches up to twice the partial root, so it needs 33 bits.
    always_comb begin
        if (mode_reg == ARITH_SQRT) begin
            a_op = {rem_reg, n_reg[63:62]};
            b_op = {1'b0, root_reg, 2'b01};
        end else begin
            a_op = {1'b0, rem_reg, n_reg[63]};
            b_op = {19'd0, d_reg};
        end
        diff = a_op - b_op;
        ge   = ~diff[34];
    end

    // Step sequencing.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        step_next = step_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            mode_next = ctrl.mode;
            step_next = 5'd0;
            n_next    = op_n;
            d_next    = op_d;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[32:0] : a_op[32:0];
            root_next = {root_reg[ARITH_R_W-2:0], ge};
            n_next    = (mode_reg == ARITH_SQRT) ? {n_reg[61:0], 2'b00}
                                                 : {n_reg[62:0], 1'b0};
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mode_reg <= mode_next;
        step_reg <= step_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done   = done_reg;
    assign result = root_reg;
endmodule

/* rtl/cteb_store.sv */
// Pixel memory: one write port and one registered read port.
// Depends on cteb_pkg for the pixel width.
module cteb_store #(
    parameter int DEPTH  = cteb_pkg::DEF_IMAGE_SIDE * cteb_pkg::DEF_IMAGE_SIDE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [cteb_pkg::VAL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [cteb_pkg::VAL_W-1:0] rdata
);
    import cteb_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* tb/tb.sv */
// Self-checking testbench for cone_tool_engrave_buffer_core: directed stimulus table,
// then random request sequences, each result checked against a behavioral image model
// or the typed row values. Depends on cteb_pkg and the RTL of cone_tool_engrave_buffer_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cteb_pkg::*;

    localparam int          SIDE_MAX     = DEF_IMAGE_SIDE;
    localparam int unsigned RADIUS_FLOOR = ((1 << DEF_FRAC_BITS) + 9) / 10;
    localparam int          IDLE_LIMIT   = 10000000;
    localparam int          DRAIN_CYCLES = 64;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [8:0]        side_val;
        logic [1:0]        req;
        logic signed [17:0] cx, cy;
        logic [15:0]       radius, depth, px, py;
        bit                typed;
        logic [15:0]       t_pix, t_min, t_max;
    } stim_row_t;

    typedef struct {
        logic [1:0]  echo;
        logic [15:0] pix, rmin, rmax;
    } result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [8:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;   // req_type[1:0]
    logic [103:0] s_tdata = '0;   // cx, cy, radius, depth, pixel_x, pixel_y, zero fill
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [1:0]   m_tuser;        // req_echo[1:0]
    logic [47:0]  m_tdata;        // pixel_value, range_min, range_max

    // Image model state.
    logic [15:0]  image_mem [SIDE_MAX*SIDE_MAX];
    logic [8:0]   side_reg = 9'd256;

    result_t      results_due[$];
    stim_row_t    plan[$];
    int           errors = 0;
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;

    cone_tool_engrave_buffer_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int eff_side();
        if (side_reg == 0) return 1;
        if (side_reg > SIDE_MAX) return SIDE_MAX;
        return int'(side_reg);
    endfunction

    function automatic longint trunc_px(longint v);
        if (v >= 0) return v >>> DEF_FRAC_BITS;
        return -((-v) >>> DEF_FRAC_BITS);
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned q = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= q + b) begin
                n -= q + b;
                q = (q >> 1) + b;
            end else begin
                q >>= 1;
            end
            b >>= 2;
        end
        return q;
    endfunction

    // Stamp the cone: each pixel inside the radius keeps the lower of old and new depth.
    function automatic void stamp_cone(longint cx, longint cy, longint unsigned r,
                                       longint unsigned d);
        int s;
        longint x0, x1, y0, y1, dx, dy;
        longint unsigned dd, val;
        s = eff_side();
        if (r < RADIUS_FLOOR) r = RADIUS_FLOOR;
        x0 = trunc_px(cx - longint'(r)); x1 = trunc_px(cx + longint'(r));
        y0 = trunc_px(cy - longint'(r)); y1 = trunc_px(cy + longint'(r));
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > s - 1) x1 = s - 1;
        if (y1 > s - 1) y1 = s - 1;
        for (longint y = y0; y <= y1; y++) begin
            for (longint x = x0; x <= x1; x++) begin
                dx = x * (1 << DEF_FRAC_BITS) - cx;
                dy = y * (1 << DEF_FRAC_BITS) - cy;
                dd = longint'(dx * dx) + longint'(dy * dy);
                if (dd < r * r) begin
                    val = root64(dd * 64'd65535 * 64'd65535) / r + (64'd65535 - d);
                    if (val < image_mem[y * s + x]) image_mem[y * s + x] = val[15:0];
                end
            end
        end
    endfunction

    // Apply one request to the image model and return the result it produces.
    function automatic result_t engrave_predict(stim_row_t t);
        result_t res;
        int s, cnt;
        logic [15:0] lo, hi;
        s = eff_side();
        cnt = s * s;
        res = '{echo: t.req, pix: 16'd0, rmin: 16'd0, rmax: 16'd0};
        case (t.req)
            REQ_CLEAR: begin
                for (int i = 0; i < cnt; i++) image_mem[i] = PIX_FULL;
            end
            REQ_CUT: begin
                stamp_cone(longint'(t.cx), longint'(t.cy), t.radius, t.depth);
            end
            REQ_NORM: begin
                lo = PIX_FULL;
                hi = 16'd0;
                for (int i = 0; i < cnt; i++) begin
                    if (image_mem[i] < lo) lo = image_mem[i];
                    if (image_mem[i] > hi) hi = image_mem[i];
                end
                for (int i = 0; i < cnt; i++) begin
                    if (hi <= lo) image_mem[i] = 16'd0;
                    else image_mem[i] = 16'((64'(image_mem[i] - lo) * 65535) / (hi - lo));
                end
                res.rmin = lo;
                res.rmax = hi;
            end
            default: begin
                if (t.px >= s || t.py >= s) res.pix = PIX_FULL;
                else res.pix = image_mem[int'(t.py) * s + int'(t.px)];
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int u;
        u = $urandom_range(0, 99);
        if (no_gaps || u < 50) return 0;
        if (u < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic stim_row_t req_row(logic [1:0] req, int cx, int cy, int radius,
                                          int depth, int px, int py);
        stim_row_t t;
        t = '{kind: ROW_REQ, side_val: '0, req: req, cx: 18'(cx), cy: 18'(cy),
              radius: 16'(radius), depth: 16'(depth), px: 16'(px), py: 16'(py),
              typed: 1'b0, t_pix: '0, t_min: '0, t_max: '0};
        return t;
    endfunction

    function automatic stim_row_t typed_row(logic [1:0] req, int px, int py, int pix,
                                            int rmin, int rmax);
        stim_row_t t;
        t = req_row(req, 0, 0, 0, 0, px, py);
        t.typed = 1'b1;
        t.t_pix = 16'(pix);
        t.t_min = 16'(rmin);
        t.t_max = 16'(rmax);
        return t;
    endfunction

    function automatic stim_row_t cfg_row(int v);
        stim_row_t t;
        t = req_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        t.kind = ROW_CFG;
        t.side_val = 9'(v);
        return t;
    endfunction

    // Send one request transaction and record its expected result on acceptance.
    task automatic send_req(stim_row_t t);
        int g;
        result_t exp_res;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.req;
        s_tdata  <= {4'b0, t.py, t.px, t.depth, t.radius, t.cy, t.cx};
        do @(posedge aclk); while (!s_tready);
        exp_res = engrave_predict(t);
        if (t.typed) exp_res = '{echo: t.req, pix: t.t_pix, rmin: t.t_min, rmax: t.t_max};
        results_due.push_back(exp_res);
    endtask

    // Register writes happen only with the block idle and every result returned.
    task automatic write_side(logic [8:0] v);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        side_reg = v;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result echo=%0d data=%h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                e = results_due.pop_front();
                if (m_tuser !== e.echo) begin
                    $display("%0t: req_echo expected %0d actual %0d", $time, e.echo, m_tuser);
                    errors++;
                end
                if (m_tdata[15:0] !== e.pix) begin
                    $display("%0t: pixel_value expected %h actual %h", $time, e.pix,
                             m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== e.rmin) begin
                    $display("%0t: range_min expected %h actual %h", $time, e.rmin,
                             m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[47:32] !== e.rmax) begin
                    $display("%0t: range_max expected %h actual %h", $time, e.rmax,
                             m_tdata[47:32]);
                    errors++;
                end
            end
        end
    end

    // Receiver backpressure: random stalls, mostly short, a few long.
    always @(posedge aclk) begin
        int u;
        u = $urandom_range(0, 99);
        if (!aresetn || no_gaps || u < 60) m_tready <= 1'b1;
        else if (u < 95) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 39) == 0);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t t;
        int s, n_items, burst, sel;

        // Directed table at the reset side of 256.
        plan.push_back(req_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        plan.push_back(typed_row(REQ_READ, 0, 0, 16'hFFFF, 0, 0));
        plan.push_back(typed_row(REQ_READ, 255, 255, 16'hFFFF, 0, 0));
        plan.push_back(typed_row(REQ_READ, 256, 0, 16'hFFFF, 0, 0));
        plan.push_back(typed_row(REQ_READ, 65535, 65535, 16'hFFFF, 0, 0));
        // Flat image: range is reported and every pixel becomes zero.
        plan.push_back(typed_row(REQ_NORM, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        plan.push_back(typed_row(REQ_READ, 7, 9, 0, 0, 0));
        plan.push_back(req_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_CUT, 5 * 256, 5 * 256, 512, 65535, 0, 0));
        // Full depth at the exact center gives zero.
        plan.push_back(typed_row(REQ_READ, 5, 5, 0, 0, 0));
        plan.push_back(req_row(REQ_CUT, 20 * 256 + 128, 20 * 256 + 128, 0, 40000, 0, 0));
        plan.push_back(req_row(REQ_CUT, -131072, 131071, 65535, 65535, 65535, 65535));
        plan.push_back(req_row(REQ_CUT, -256, 30 * 256, 1024, 30000, 0, 0));
        plan.push_back(req_row(REQ_CUT, 40 * 256, 40 * 256, 2000, 0, 0, 0));
        plan.push_back(req_row(REQ_NORM, 0, 0, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 0, 5, 5));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 0, 21, 20));
        // Side 0 acts as a single pixel.
        plan.push_back(cfg_row(0));
        plan.push_back(req_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_CUT, 0, 0, 300, 12345, 0, 0));
        plan.push_back(req_row(REQ_NORM, 0, 0, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 0, 0, 0));
        plan.push_back(typed_row(REQ_READ, 1, 0, 16'hFFFF, 0, 0));
        // Side above the image size is clamped.
        plan.push_back(cfg_row(511));
        plan.push_back(req_row(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_CUT, 255 * 256 + 100, 255 * 256 + 200, 600, 65535, 0, 0));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 0, 255, 255));
        plan.push_back(typed_row(REQ_READ, 256, 255, 16'hFFFF, 0, 0));

        for (int i = 0; i < SIDE_MAX * SIDE_MAX; i++) image_mem[i] = 16'd0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) write_side(plan[i].side_val);
            else send_req(plan[i]);
        end

        // Random phases: a new side, a clear, then a mixed run of requests.
        n_items = 0;
        while (n_items < 64) begin
            write_side(9'($urandom_range(1, 20)));
            s = eff_side();
            no_gaps = ($urandom_range(0, 3) == 0);
            send_req(req_row(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom));
            burst = $urandom_range(4, 15);
            for (int k = 0; k < burst; k++) begin
                sel = $urandom_range(0, 99);
                t = req_row(REQ_CUT, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
                if (sel < 50) begin
                    if ($urandom_range(0, 9) < 8) begin
                        t.cx = 18'(int'($urandom_range(0, s * 256 + 511)) - 256);
                        t.cy = 18'(int'($urandom_range(0, s * 256 + 511)) - 256);
                        t.radius = 16'($urandom_range(0, s * 256));
                    end
                end else if (sel < 82) begin
                    t.req = REQ_READ;
                    if ($urandom_range(0, 9) < 8) begin
                        t.px = 16'($urandom_range(0, s + 1));
                        t.py = 16'($urandom_range(0, s + 1));
                    end
                end else if (sel < 95) begin
                    t.req = REQ_NORM;
                end else begin
                    t.req = REQ_CLEAR;
                end
                send_req(t);
                n_items++;
            end
            no_gaps = 1'b0;
        end

        // Drain outstanding results, then allow the block to settle.
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
